@@ src/iac_pkg.sv @@
// Shared constants, types and the coefficient slot decoder for the IMU affine calibration block.
// No dependencies; imported by every other file of the block.
`timescale 1ns / 1ps

package iac_pkg;

   localparam int FRAC_BITS          = 16;
   localparam int NUM_LANES          = 3;
   localparam int WORDS_PER_SENSOR   = 12;
   localparam int WORD_IDX_WIDTH     = 4;
   localparam int SLOT_WIDTH         = 6;
   localparam int SCALE_WIDTH        = 24;
   localparam int CSR_IDX_WIDTH      = 1;

   localparam int DEF_SAMPLE_WIDTH   = 16;
   localparam int DEF_COEF_WIDTH     = 32;
   localparam int DEF_OUT_WIDTH      = 24;

   localparam logic [SCALE_WIDTH-1:0]   SCALE_RESET      = SCALE_WIDTH'(65536);

   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAG_SCALE    = 1'b0;
   localparam logic [CSR_IDX_WIDTH-1:0] CSR_MAG_SCALE_EN = 1'b1;

   localparam logic CMD_SAMPLE = 1'b0;
   localparam logic CMD_WRITE  = 1'b1;

   typedef struct packed {
      logic en1;   // product registers
      logic en2;   // rounded lane results
      logic en3;   // scale products
      logic en4;   // output register
   } iac_stage_en_type;

   typedef struct packed {
      logic                      en;
      logic [WORD_IDX_WIDTH-1:0] word;
   } iac_wr_type;

   typedef struct packed {
      logic                      valid;
      logic [1:0]                lane;
      logic [WORD_IDX_WIDTH-1:0] word;
   } iac_slot_type;

   // slot = sensor*12 + word; anything from 36 up is dropped
   function automatic iac_slot_type decode_slot(input logic [SLOT_WIDTH-1:0] slot);
      iac_slot_type d;
      d.valid = 1'b1;
      d.lane  = 2'd0;
      d.word  = slot[WORD_IDX_WIDTH-1:0];
      if (slot < SLOT_WIDTH'(WORDS_PER_SENSOR)) begin
         d.lane = 2'd0;
         d.word = slot[WORD_IDX_WIDTH-1:0];
      end else if (slot < SLOT_WIDTH'(2 * WORDS_PER_SENSOR)) begin
         d.lane = 2'd1;
         d.word = WORD_IDX_WIDTH'(slot - SLOT_WIDTH'(WORDS_PER_SENSOR));
      end else if (slot < SLOT_WIDTH'(3 * WORDS_PER_SENSOR)) begin
         d.lane = 2'd2;
         d.word = WORD_IDX_WIDTH'(slot - SLOT_WIDTH'(2 * WORDS_PER_SENSOR));
      end else begin
         d.valid = 1'b0;
      end
      return d;
   endfunction

endpackage

@@ src/iac_lane.sv @@
// One sensor lane: 12-word coefficient bank, 3x3 multiply plus offset, round and saturate.
// Depends on iac_pkg. Two register stages (products, then saturated results).
`timescale 1ns / 1ps

module iac_lane #(
   parameter int SAMPLE_WIDTH = iac_pkg::DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = iac_pkg::DEF_COEF_WIDTH,
   parameter int OUT_WIDTH    = iac_pkg::DEF_OUT_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  iac_pkg::iac_stage_en_type           stage_en,
   input  iac_pkg::iac_wr_type                 wr,
   input  logic [COEF_WIDTH-1:0]               wr_data,
   input  logic [2:0][SAMPLE_WIDTH-1:0]        vec,
   output logic [2:0][OUT_WIDTH-1:0]           res
);
   import iac_pkg::*;

   localparam int PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
   localparam int SUM_W  = (PROD_W + 2 > OUT_WIDTH + FRAC_BITS + 1) ?
                           PROD_W + 2 : OUT_WIDTH + FRAC_BITS + 1;
   localparam int RND_W  = SUM_W - FRAC_BITS;
   localparam logic [COEF_WIDTH-1:0] COEF_ONE = COEF_WIDTH'(64'd1 << FRAC_BITS);
   localparam logic [SUM_W-1:0]      HALF     = SUM_W'(64'd1 << (FRAC_BITS - 1));
   localparam logic [OUT_WIDTH-1:0]  OUT_MAX  = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic [OUT_WIDTH-1:0]  OUT_MIN  = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   logic [WORDS_PER_SENSOR-1:0][COEF_WIDTH-1:0] coef_ff;
   logic signed [PROD_W-1:0]     prod_in [3][3];
   logic signed [PROD_W-1:0]     prod_ff [3][3];
   logic [2:0][COEF_WIDTH-1:0]   off_ff;
   logic [2:0][OUT_WIDTH-1:0]    res_in;
   logic [2:0][OUT_WIDTH-1:0]    res_ff;
   logic signed [SUM_W-1:0]      sum [3];
   logic [RND_W-1:0]             rnd [3];
   logic [RND_W-OUT_WIDTH:0]     upper [3];

   // bank resets to the identity matrix with zero offset
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WORDS_PER_SENSOR; k++) begin
            coef_ff[k] <= (k == 0 || k == 4 || k == 8) ? COEF_ONE : '0;
         end
      end else if (wr.en) begin
         coef_ff[wr.word] <= wr_data;
      end
   end

   // column-major: M[i*3+j] weights input i into output j
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         for (int j = 0; j < 3; j++) begin
            prod_in[i][j] = $signed(vec[i]) * $signed(coef_ff[i*3+j]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.en1) begin
         prod_ff <= prod_in;
         for (int j = 0; j < 3; j++) begin
            off_ff[j] <= coef_ff[9+j];
         end
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sum[j] = SUM_W'(prod_ff[0][j]) + SUM_W'(prod_ff[1][j]) + SUM_W'(prod_ff[2][j])
                + SUM_W'($signed(off_ff[j])) + $signed(HALF);
         rnd[j]   = sum[j][SUM_W-1:FRAC_BITS];
         upper[j] = rnd[j][RND_W-1:OUT_WIDTH-1];
         if ((&upper[j]) || !(|upper[j])) begin
            res_in[j] = rnd[j][OUT_WIDTH-1:0];
         end else begin
            res_in[j] = rnd[j][RND_W-1] ? OUT_MIN : OUT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.en2) begin
         res_ff <= res_in;
      end
   end

   assign res = res_ff;

endmodule

@@ src/iac_merge.sv @@
// Merging stage: gathers the three lane results, applies the optional magnetometer scale,
// and holds the output register. Depends on iac_pkg.
`timescale 1ns / 1ps

module iac_merge #(
   parameter int OUT_WIDTH = iac_pkg::DEF_OUT_WIDTH
) (
   input  logic                                        clock,
   input  iac_pkg::iac_stage_en_type                   stage_en,
   input  logic [2:0][2:0][OUT_WIDTH-1:0]              lane_res,
   input  logic [iac_pkg::SCALE_WIDTH-1:0]             mag_scale,
   input  logic                                        mag_scale_enable,
   output logic [2:0][2:0][OUT_WIDTH-1:0]              merged
);
   import iac_pkg::*;

   localparam int MAG_LANE = 2;
   localparam int PW       = OUT_WIDTH + SCALE_WIDTH + 1;
   localparam int RND_W    = PW - FRAC_BITS;
   localparam logic [PW-1:0]        HALF    = PW'(64'd1 << (FRAC_BITS - 1));
   localparam logic [OUT_WIDTH-1:0] OUT_MAX = {1'b0, {(OUT_WIDTH-1){1'b1}}};
   localparam logic [OUT_WIDTH-1:0] OUT_MIN = {1'b1, {(OUT_WIDTH-1){1'b0}}};

   logic [2:0][2:0][OUT_WIDTH-1:0] pass_ff;
   logic signed [PW-1:0]           mprod_ff [3];
   logic signed [PW-1:0]           mprod_in [3];
   logic signed [PW-1:0]           biased [3];
   logic [RND_W-1:0]               rnd [3];
   logic [RND_W-OUT_WIDTH:0]       upper [3];
   logic [2:0][OUT_WIDTH-1:0]      scaled;
   logic [2:0][2:0][OUT_WIDTH-1:0] merged_ff;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         mprod_in[k] = $signed(lane_res[MAG_LANE][k]) * $signed({1'b0, mag_scale});
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.en3) begin
         pass_ff  <= lane_res;
         mprod_ff <= mprod_in;
      end
   end

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         biased[k] = mprod_ff[k] + $signed(HALF);
         rnd[k]    = biased[k][PW-1:FRAC_BITS];
         upper[k]  = rnd[k][RND_W-1:OUT_WIDTH-1];
         if ((&upper[k]) || !(|upper[k])) begin
            scaled[k] = rnd[k][OUT_WIDTH-1:0];
         end else begin
            scaled[k] = rnd[k][RND_W-1] ? OUT_MIN : OUT_MAX;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en.en4) begin
         merged_ff[0] <= pass_ff[0];
         merged_ff[1] <= pass_ff[1];
         merged_ff[MAG_LANE] <= mag_scale_enable ? scaled : pass_ff[MAG_LANE];
      end
   end

   assign merged = merged_ff;

endmodule

@@ src/imu_affine_calibration.sv @@
// IMU affine calibration top level: three sensor lanes, merging/scale stage, stream ports.
// Sample results leave on rsp_; throughput is one item a cycle while rsp_tready does not stall.
// The four register stages are products, round/saturate, scale multiply and output register.
// A coefficient write gives no result. Reset empties the pipeline, loads identity matrices with
// zero offsets, sets mag_scale to 1.0 and clears mag_scale_enable.
// Depends on iac_pkg, iac_lane, iac_merge.
`timescale 1ns / 1ps

module imu_affine_calibration #(
   parameter int SAMPLE_WIDTH = iac_pkg::DEF_SAMPLE_WIDTH,
   parameter int COEF_WIDTH   = iac_pkg::DEF_COEF_WIDTH,
   parameter int OUT_WIDTH    = iac_pkg::DEF_OUT_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // gyro_x, gyro_y, gyro_z, accel_x, accel_y, accel_z, magnet_x, magnet_y, magnet_z,
   // coef_slot, coef_value; zero padded to bytes
   input  logic [((9*SAMPLE_WIDTH + iac_pkg::SLOT_WIDTH + COEF_WIDTH + 7) / 8) * 8 - 1:0]
                req_tdata,
   input  logic req_tuser,   // command
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // gyro_out_x/y/z, accel_out_x/y/z, magnet_out_x/y/z; zero padded to bytes
   output logic [((9*OUT_WIDTH + 7) / 8) * 8 - 1:0] rsp_tdata,
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [iac_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [iac_pkg::SCALE_WIDTH-1:0]   csr_data
);
   import iac_pkg::*;

   localparam int RSP_W    = ((9*OUT_WIDTH + 7) / 8) * 8;
   localparam int SLOT_LSB = 9 * SAMPLE_WIDTH;
   localparam int COEF_LSB = SLOT_LSB + SLOT_WIDTH;

   logic                           v1_ff, v2_ff, v3_ff, out_valid_ff;
   logic                           req_accept, sample_accept;
   iac_stage_en_type               stage_en;
   iac_slot_type                   slot;
   iac_wr_type                     wr [NUM_LANES];
   logic [NUM_LANES-1:0][2:0][SAMPLE_WIDTH-1:0] vec;
   logic [2:0][2:0][OUT_WIDTH-1:0] lane_res;
   logic [2:0][2:0][OUT_WIDTH-1:0] merged;
   logic [SCALE_WIDTH-1:0]         mag_scale_ff;
   logic                           mag_scale_en_ff;

   // each stage moves on when it is empty or the one after it moves
   assign stage_en.en4 = !out_valid_ff || rsp_tready;
   assign stage_en.en3 = !v3_ff || stage_en.en4;
   assign stage_en.en2 = !v2_ff || stage_en.en3;
   assign stage_en.en1 = !v1_ff || stage_en.en2;

   assign req_tready    = stage_en.en1;
   assign req_accept    = req_tvalid && req_tready;
   assign sample_accept = req_accept && (req_tuser == CMD_SAMPLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (stage_en.en1) v1_ff        <= sample_accept;
         if (stage_en.en2) v2_ff        <= v1_ff;
         if (stage_en.en3) v3_ff        <= v2_ff;
         if (stage_en.en4) out_valid_ff <= v3_ff;
      end
   end

   assign slot = decode_slot(req_tdata[SLOT_LSB +: SLOT_WIDTH]);

   genvar s;
   generate
      for (s = 0; s < NUM_LANES; s++) begin : g_lane
         assign wr[s].en   = req_accept && (req_tuser == CMD_WRITE) && slot.valid &&
                             (slot.lane == 2'(s));
         assign wr[s].word = slot.word;
         assign vec[s]     = req_tdata[s*3*SAMPLE_WIDTH +: 3*SAMPLE_WIDTH];

         iac_lane #(
            .SAMPLE_WIDTH (SAMPLE_WIDTH),
            .COEF_WIDTH   (COEF_WIDTH),
            .OUT_WIDTH    (OUT_WIDTH)
         ) u_lane (
            .clock    (clock),
            .reset    (reset),
            .stage_en (stage_en),
            .wr       (wr[s]),
            .wr_data  (req_tdata[COEF_LSB +: COEF_WIDTH]),
            .vec      (vec[s]),
            .res      (lane_res[s])
         );
      end
   endgenerate

   iac_merge #(
      .OUT_WIDTH (OUT_WIDTH)
   ) u_merge (
      .clock            (clock),
      .stage_en         (stage_en),
      .lane_res         (lane_res),
      .mag_scale        (mag_scale_ff),
      .mag_scale_enable (mag_scale_en_ff),
      .merged           (merged)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         mag_scale_ff    <= SCALE_RESET;
         mag_scale_en_ff <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_MAG_SCALE:    mag_scale_ff    <= csr_data;
            CSR_MAG_SCALE_EN: mag_scale_en_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = RSP_W'(merged);

   // a write transfer never occupies a pipeline slot
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == CMD_WRITE) |=> !v1_ff)
      else $error("write transfer entered the pipeline");

   // back-pressure on the input only once every stage is full
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (v1_ff && v2_ff && v3_ff && out_valid_ff))
      else $error("input stalled with a bubble in the pipeline");

   // a stalled full scale stage keeps its item
   assert property (@(posedge clock) disable iff (reset)
      (v3_ff && !stage_en.en3) |=> v3_ff)
      else $error("scale stage lost an item while stalled");

endmodule

@@ dv/imu_affine_calibration_tb.sv @@
// Self-checking testbench for imu_affine_calibration: random and directed sample and
// coefficient-write transfers, scoreboarded against an in-bench affine correction model.
// Depends on iac_pkg and the imu_affine_calibration RTL.
`timescale 1ns / 1ps

module imu_affine_calibration_tb;
   import iac_pkg::*;

   localparam int SAMPLE_W     = DEF_SAMPLE_WIDTH;
   localparam int COEF_W       = DEF_COEF_WIDTH;
   localparam int OUT_W        = DEF_OUT_WIDTH;
   localparam int TABLE_WORDS  = 3 * WORDS_PER_SENSOR;
   localparam int OFFSET_WORD  = 9;
   localparam int REQ_BITS     = ((9 * SAMPLE_W + SLOT_WIDTH + COEF_W + 7) / 8) * 8;
   localparam int RSP_BITS     = ((9 * OUT_W + 7) / 8) * 8;
   localparam int DRAIN_CYCLES = 12;
   localparam int CYCLE_LIMIT  = 250000;
   localparam int PHASE_ITEMS  = 162;
   localparam int NUM_PHASES   = 6;
   localparam longint OUT_MAX  = (longint'(1) << (OUT_W - 1)) - 1;
   localparam longint OUT_MIN  = -(longint'(1) << (OUT_W - 1));
   localparam logic [COEF_W-1:0] UNITY = COEF_W'(1 << FRAC_BITS);

   // packed so that vec[0] (gyro_x) lands in the lowest bits of tdata
   typedef struct packed {
      logic signed [COEF_W-1:0]  value;
      logic [SLOT_WIDTH-1:0]     slot;
      logic [8:0][SAMPLE_W-1:0]  vec;
   } req_payload_type;

   typedef struct packed {
      logic            cmd;
      req_payload_type payload;
   } req_item_type;

   typedef logic [8:0][OUT_W-1:0] vectors_type;

   typedef enum logic [1:0] {READY_ALWAYS, READY_COIN, READY_SPARSE, READY_BLOCKS}
      ready_mode_type;

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_BITS-1:0]      req_tdata  = '0;
   logic                     req_tuser  = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_BITS-1:0]      rsp_tdata;
   logic                     csr_valid  = 1'b0;
   logic                     csr_ready;
   logic [CSR_IDX_WIDTH-1:0] csr_index  = '0;
   logic [SCALE_WIDTH-1:0]   csr_data   = '0;

   logic signed [COEF_W-1:0] coef_model [TABLE_WORDS];
   logic [SCALE_WIDTH-1:0]   scale_model;
   logic                     scale_en_model;

   req_item_type req_items [$];
   vectors_type  calibrated_q [$];
   int           error_count = 0;
   int           cycle_count = 0;
   int           gap_left    = 0;
   int           burst_left  = 0;

   ready_mode_type ready_mode  = READY_ALWAYS;
   int             mode_left   = 0;
   int             block_left  = 0;
   int             sparse_tick = 0;

   string sensor_tag [3] = '{"gyro", "accel", "magnet"};
   string axis_tag [3]   = '{"x", "y", "z"};

   imu_affine_calibration u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   // round half up from Q.16, then clamp to the output width
   function automatic longint round_sat(input longint acc);
      longint r;
      r = (acc + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
      if (r > OUT_MAX)
         r = OUT_MAX;
      else if (r < OUT_MIN)
         r = OUT_MIN;
      return r;
   endfunction

   function automatic vectors_type calibrate(input req_payload_type p);
      vectors_type res;
      longint      acc;
      int          base;
      for (int s = 0; s < 3; s++) begin
         base = s * WORDS_PER_SENSOR;
         for (int j = 0; j < 3; j++) begin
            acc = longint'(coef_model[base + OFFSET_WORD + j]);
            for (int i = 0; i < 3; i++)
               acc += longint'($signed(p.vec[s * 3 + i]))
                    * longint'(coef_model[base + i * 3 + j]);
            acc = round_sat(acc);
            if (s == 2 && scale_en_model)
               acc = round_sat(acc * longint'(scale_model));
            res[s * 3 + j] = acc[OUT_W-1:0];
         end
      end
      return res;
   endfunction

   function automatic req_payload_type random_payload(input bit narrow);
      req_payload_type p;
      for (int k = 0; k < 9; k++)
         p.vec[k] = narrow ? SAMPLE_W'($urandom_range(0, 4000) - 2000) : SAMPLE_W'($urandom);
      p.slot  = SLOT_WIDTH'($urandom);
      p.value = $urandom;
      return p;
   endfunction

   task automatic push_item(input logic cmd, input req_payload_type p);
      req_item_type it;
      it.cmd     = cmd;
      it.payload = p;
      req_items.push_back(it);
   endtask

   task automatic push_coef(input int slot, input logic [COEF_W-1:0] value);
      req_payload_type p;
      p       = random_payload(1'b0);
      p.slot  = SLOT_WIDTH'(slot);
      p.value = value;
      push_item(CMD_WRITE, p);
   endtask

   // writes give no result, so allow the pipeline to empty past the last result
   task automatic wait_drained();
      do @(negedge clock);
      while (req_items.size() != 0 || req_tvalid || calibrated_q.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_WIDTH-1:0] idx,
                            input logic [SCALE_WIDTH-1:0] data);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic run_random(input int count);
      req_payload_type p;
      int              pick;
      for (int n = 0; n < count; n++) begin
         p = random_payload($urandom_range(0, 1));
         if ($urandom_range(0, 4) == 0) begin
            pick = $urandom_range(0, 9);
            if ($urandom_range(0, 15) == 0)
               p.slot = SLOT_WIDTH'($urandom_range(TABLE_WORDS, 63));
            else
               p.slot = SLOT_WIDTH'($urandom_range(0, TABLE_WORDS - 1));
            case (pick)
               0: p.value = $urandom;
               1: p.value = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
               2: p.value = '0;
               3, 4: p.value = UNITY + COEF_W'($urandom_range(0, 8192)) - COEF_W'(4096);
               default: p.value = COEF_W'($urandom_range(0, 3 * UNITY)) - COEF_W'(3 * UNITY / 2);
            endcase
            push_item(CMD_WRITE, p);
         end else begin
            push_item(CMD_SAMPLE, p);
         end
      end
   endtask

   // request driver: bursts of transfers separated by random gaps
   always @(posedge clock) begin : req_driver
      req_item_type next_item;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (gap_left > 0) begin
            gap_left--;
            req_tvalid <= 1'b0;
         end else if (req_items.size() > 0) begin
            next_item = req_items.pop_front();
            req_tvalid <= 1'b1;
            req_tuser  <= next_item.cmd;
            req_tdata  <= REQ_BITS'(next_item.payload);
            if (burst_left > 0) begin
               burst_left--;
            end else begin
               burst_left = $urandom_range(0, 15);
               gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            end
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   // response backpressure, switching at random among four ready patterns
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (mode_left == 0) begin
            ready_mode = ready_mode_type'($urandom_range(0, 3));
            mode_left  = $urandom_range(16, 96);
         end else begin
            mode_left--;
         end
         sparse_tick++;
         case (ready_mode)
            READY_ALWAYS: rsp_tready <= 1'b1;
            READY_COIN:   rsp_tready <= $urandom_range(0, 1);
            READY_SPARSE: rsp_tready <= (sparse_tick % 4 == 0);
            default: begin
               if (block_left > 0) begin
                  block_left--;
                  rsp_tready <= 1'b0;
               end else begin
                  block_left = $urandom_range(0, 12);
                  rsp_tready <= 1'b1;
               end
            end
         endcase
      end
   end

   always @(posedge clock) begin : scoreboard
      req_payload_type got_req;
      vectors_type     want;
      vectors_type     got;
      if (reset) begin
         for (int w = 0; w < TABLE_WORDS; w++)
            coef_model[w] = ((w % WORDS_PER_SENSOR) < OFFSET_WORD &&
                             (w % WORDS_PER_SENSOR) % 4 == 0) ? UNITY : '0;
         scale_model    = SCALE_RESET;
         scale_en_model = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_MAG_SCALE)
               scale_model = csr_data;
            else if (csr_index == CSR_MAG_SCALE_EN)
               scale_en_model = csr_data[0];
         end
         if (req_tvalid && req_tready) begin
            got_req = req_tdata[$bits(req_payload_type)-1:0];
            if (req_tuser == CMD_WRITE) begin
               if (got_req.slot < TABLE_WORDS)
                  coef_model[got_req.slot] = got_req.value;
            end else begin
               calibrated_q.push_back(calibrate(got_req));
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata;
            if (calibrated_q.size() == 0) begin
               error_count++;
               $error("result transfer with no corrected vector waiting");
            end else begin
               want = calibrated_q.pop_front();
               for (int k = 0; k < 9; k++) begin
                  if (got[k] !== want[k]) begin
                     error_count++;
                     $error("%s_out_%s: expected %0d, got %0d", sensor_tag[k / 3],
                            axis_tag[k % 3], $signed(want[k]), $signed(got[k]));
                  end
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("imu_affine_calibration verification failed");
         $finish;
      end
   end

   initial begin
      req_payload_type        p;
      logic [SCALE_WIDTH-1:0] phase_scale [NUM_PHASES];
      logic                   phase_en [NUM_PHASES];
      phase_scale = '{24'd0, 24'hFF_FFFF, 24'd32768, SCALE_WIDTH'($urandom),
                      SCALE_RESET, SCALE_WIDTH'($urandom)};
      phase_en    = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0};
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // identity table: extremes pass straight through
      p = random_payload(1'b0);
      p.vec = '0;
      push_item(CMD_SAMPLE, p);
      p.vec = {9{16'h7FFF}};
      push_item(CMD_SAMPLE, p);
      p.vec = {9{16'h8000}};
      push_item(CMD_SAMPLE, p);
      p.vec = {16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF,
               16'h8000, 16'h7FFF};
      push_item(CMD_SAMPLE, p);

      // half-unit gyro offsets: rounding ties go towards plus infinity
      push_coef(OFFSET_WORD, 32'h0000_8000);
      push_coef(OFFSET_WORD + 1, 32'hFFFF_8000);
      push_coef(OFFSET_WORD + 2, 32'h0001_8000);
      p.vec = '0;
      push_item(CMD_SAMPLE, p);
      p.vec = {9{16'hFFFF}};
      push_item(CMD_SAMPLE, p);

      // extreme accel gains drive both saturation limits
      push_coef(WORDS_PER_SENSOR, 32'h7FFF_FFFF);
      push_coef(WORDS_PER_SENSOR + 1, 32'h8000_0000);
      p.vec = {9{16'h7FFF}};
      push_item(CMD_SAMPLE, p);
      p.vec = {9{16'h8000}};
      push_item(CMD_SAMPLE, p);

      // out-of-range slots are dropped, zero coefficient stored as given
      push_coef(TABLE_WORDS, $urandom);
      push_coef(63, $urandom);
      push_coef(2 * WORDS_PER_SENSOR + 4, '0);
      push_coef(TABLE_WORDS - 1, 3 * UNITY);
      push_item(CMD_SAMPLE, random_payload(1'b0));
      p.vec = {16'h8000, 16'h7FFF, 16'h8000, {6{16'h0001}}};
      push_item(CMD_SAMPLE, p);

      run_random(PHASE_ITEMS);

      for (int ph = 0; ph < NUM_PHASES; ph++) begin
         wait_drained();
         write_csr(CSR_MAG_SCALE, phase_scale[ph]);
         write_csr(CSR_MAG_SCALE_EN, {(SCALE_WIDTH - 1)'($urandom), phase_en[ph]});
         run_random(PHASE_ITEMS);
      end

      wait_drained();
      if (error_count == 0)
         $display("imu_affine_calibration verification clean");
      else
         $display("imu_affine_calibration verification failed");
      $finish;
   end

endmodule

@@ imu_affine_calibration.f @@
src/iac_pkg.sv
src/iac_lane.sv
src/iac_merge.sv
src/imu_affine_calibration.sv
dv/imu_affine_calibration_tb.sv
